FILE: hdl/cts_pkg.sv
package cts_pkg;

    // Fixed field widths
    localparam int TIME_W        = 16;
    localparam int PRI_W         = 8;
    localparam int SLOT_W        = 3;
    localparam int QUANT_W       = 8;
    localparam int TCOUNT_W      = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int MAX_TASKS_DEF = 8;

    localparam logic [TIME_W-1:0]  TIME_MAX      = '1;
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd2;

    // Request commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Scheduling policies
    localparam logic [1:0] POL_FCFS     = 2'd0;
    localparam logic [1:0] POL_RR       = 2'd1;
    localparam logic [1:0] POL_PRIO     = 2'd2;
    localparam logic [1:0] POL_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_EXEC,
        ST_EMIT
    } cts_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan_step;
        logic pop_step;
        logic exec;
        logic emit;
    } cts_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_load;
        logic scan_last;
        logic pop_need;
        logic pop_end;
        logic out_free;
    } cts_status_t;

endpackage

FILE: hdl/cts_in_if.sv
interface cts_in_if import cts_pkg::*;;
    logic                valid;
    logic                ready;
    logic                command;
    logic [SLOT_W-1:0]   slot_index;
    logic [TIME_W-1:0]   entry_arrival;
    logic [TIME_W-1:0]   entry_burst;
    logic [PRI_W-1:0]    entry_priority;

    modport source (
        output valid, command, slot_index, entry_arrival, entry_burst, entry_priority,
        input  ready
    );
    modport sink (
        input  valid, command, slot_index, entry_arrival, entry_burst, entry_priority,
        output ready
    );
endinterface

FILE: hdl/cts_out_if.sv
interface cts_out_if import cts_pkg::*;;
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   time_now;
    logic                running_valid;
    logic [SLOT_W-1:0]   running_slot;
    logic                done_valid;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic                all_done;

    modport source (
        output valid, time_now, running_valid, running_slot, done_valid,
               turnaround, waiting, all_done,
        input  ready
    );
    modport sink (
        input  valid, time_now, running_valid, running_slot, done_valid,
               turnaround, waiting, all_done,
        output ready
    );
endinterface

FILE: hdl/cts_ctrl.sv
module cts_ctrl import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cts_status_t status,
    output cts_cmd_t    cmd
);

    cts_state_t state_reg;
    cts_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    state_next = status.in_load ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = status.pop_need ? ST_POP : ST_EXEC;
                end
            end
            ST_POP:
            begin
                if (status.pop_end)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    cmd.pop_step = 1'b1;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/cts_datapath.sv
module cts_datapath import cts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    localparam int IDX_W = $clog2(MAX_TASKS),
    localparam int CNT_W = $clog2(MAX_TASKS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_command,
    input  logic [SLOT_W-1:0]     in_slot_index,
    input  logic [TIME_W-1:0]     in_arrival,
    input  logic [TIME_W-1:0]     in_burst,
    input  logic [PRI_W-1:0]      in_priority,
    input  cts_cmd_t              cmd,
    output cts_status_t           status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [TIME_W-1:0]     out_time_now,
    output logic                  out_running_valid,
    output logic [SLOT_W-1:0]     out_running_slot,
    output logic                  out_done_valid,
    output logic [TIME_W-1:0]     out_turnaround,
    output logic [TIME_W-1:0]     out_waiting,
    output logic                  out_all_done
);

    // Configuration
    logic [1:0]          policy_reg;
    logic [QUANT_W-1:0]  quantum_reg;
    logic [TCOUNT_W-1:0] task_count_reg;

    // Slot tables (undefined until loaded)
    logic [TIME_W-1:0] slot_arrival_reg   [MAX_TASKS];
    logic [TIME_W-1:0] slot_burst_reg     [MAX_TASKS];
    logic [TIME_W-1:0] slot_remaining_reg [MAX_TASKS];
    logic [PRI_W-1:0]  slot_priority_reg  [MAX_TASKS];
    logic              slot_done_reg      [MAX_TASKS];
    logic [IDX_W-1:0]  ring_reg           [MAX_TASKS];
    logic              slot_queued_reg    [MAX_TASKS];

    // Scheduler state
    logic [TIME_W-1:0]  clock_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   run_slot_reg;
    logic               run_flag_reg;
    logic [QUANT_W-1:0] slice_reg;

    // Per-request working state
    logic               item_load_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               best_found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               pop_found_reg;
    logic [IDX_W-1:0]   pop_slot_reg;
    logic               res_run_reg;
    logic [IDX_W-1:0]   res_slot_reg;
    logic               res_done_reg;
    logic [TIME_W-1:0]  res_turn_reg;
    logic [TIME_W-1:0]  res_wait_reg;

    // Output register
    logic               out_valid_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic               out_run_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_done_reg;
    logic [TIME_W-1:0]  out_turn_reg;
    logic [TIME_W-1:0]  out_wait_reg;
    logic               out_all_reg;

    logic [1:0]          pol;
    logic                is_rr;
    logic                is_prio;
    logic                is_fcfs;
    logic [CNT_W-1:0]    n_use;
    logic                all_done;
    logic                load_ok;
    logic [IDX_W-1:0]    load_idx;
    logic                run_stale;

    logic [IDX_W-1:0]    si;
    logic                scan_elig;
    logic                scan_push;
    logic                scan_take;
    logic                scan_last;

    logic [IDX_W-1:0]    head_slot;
    logic                pop_hit;
    logic [IDX_W-1:0]    head_inc;

    logic                sel_valid;
    logic [IDX_W-1:0]    sel;
    logic                slice_clear;
    logic [TIME_W-1:0]   rem_dec;
    logic                finish;
    logic [TIME_W-1:0]   done_at;
    logic [TIME_W-1:0]   turn;
    logic [TIME_W-1:0]   wait_t;
    logic [QUANT_W-1:0]  slice_base;
    logic [QUANT_W-1:0]  slice_inc;
    logic [QUANT_W-1:0]  q_eff;
    logic                expire;

    logic                push_en;
    logic [IDX_W-1:0]    push_slot;
    logic [IDX_W:0]      push_sum;
    logic [IDX_W-1:0]    push_pos;

    // Policy decode and slots in use
    always_comb
    begin
        pol     = (policy_reg == POL_RESERVED) ? POL_FCFS : policy_reg;
        is_rr   = (pol == POL_RR);
        is_prio = (pol == POL_PRIO);
        is_fcfs = (pol == POL_FCFS);
        if (int'(task_count_reg) > MAX_TASKS)
        begin
            n_use = CNT_W'(MAX_TASKS);
        end
        else
        begin
            n_use = CNT_W'(task_count_reg);
        end
    end

    // Every slot in use has completed
    always_comb
    begin
        all_done = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (CNT_W'(i) < n_use && !slot_done_reg[i])
            begin
                all_done = 1'b0;
            end
        end
    end

    assign load_ok   = (int'(in_slot_index) < MAX_TASKS);
    assign load_idx  = IDX_W'(in_slot_index);
    assign run_stale = run_flag_reg &&
                       (CNT_W'(run_slot_reg) >= n_use || slot_done_reg[run_slot_reg]);

    // Slot scan, one slot a cycle
    always_comb
    begin
        si        = scan_idx_reg;
        scan_last = (scan_idx_reg == IDX_W'(MAX_TASKS - 1));
        scan_elig = (CNT_W'(si) < n_use) && !slot_done_reg[si] &&
                    (slot_arrival_reg[si] <= clock_reg);
        scan_push = scan_elig && !slot_queued_reg[si] &&
                    !(run_flag_reg && run_slot_reg == si);
        scan_take = scan_elig &&
                    (!best_found_reg ||
                     (is_prio && slot_priority_reg[si] < slot_priority_reg[best_idx_reg]) ||
                     (is_fcfs && slot_arrival_reg[si] < slot_arrival_reg[best_idx_reg]));
    end

    // Ring head pop, stale entries dropped
    always_comb
    begin
        head_slot = ring_reg[head_reg];
        pop_hit   = (CNT_W'(head_slot) < n_use) && !slot_done_reg[head_slot];
        head_inc  = (head_reg == IDX_W'(MAX_TASKS - 1)) ? '0 : head_reg + 1'b1;
    end

    // Selection and one tick of execution
    always_comb
    begin
        slice_clear = 1'b0;
        if (is_rr)
        begin
            sel_valid = run_flag_reg || pop_found_reg;
            sel       = run_flag_reg ? run_slot_reg : pop_slot_reg;
            slice_clear = !run_flag_reg;
        end
        else if (run_flag_reg)
        begin
            sel_valid = 1'b1;
            sel       = run_slot_reg;
            if (is_prio && best_found_reg &&
                slot_priority_reg[best_idx_reg] < slot_priority_reg[run_slot_reg])
            begin
                sel         = best_idx_reg;
                slice_clear = 1'b1;
            end
        end
        else
        begin
            sel_valid   = best_found_reg;
            sel         = best_idx_reg;
            slice_clear = 1'b1;
        end

        rem_dec = (slot_remaining_reg[sel] == '0) ? '0 : slot_remaining_reg[sel] - 1'b1;
        finish  = (rem_dec == '0);
        done_at = (clock_reg == TIME_MAX) ? TIME_MAX : clock_reg + 1'b1;
        turn    = (done_at >= slot_arrival_reg[sel]) ? done_at - slot_arrival_reg[sel] : '0;
        wait_t  = (turn >= slot_burst_reg[sel]) ? turn - slot_burst_reg[sel] : '0;

        slice_base = slice_clear ? '0 : slice_reg;
        slice_inc  = slice_base + 1'b1;
        q_eff      = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
        expire     = is_rr && (slice_inc >= q_eff);
    end

    // Ring tail push
    always_comb
    begin
        push_en   = 1'b0;
        push_slot = si;
        if (cmd.scan_step && is_rr && scan_push)
        begin
            push_en = 1'b1;
        end
        else if (cmd.exec && sel_valid && !finish && expire)
        begin
            push_en   = 1'b1;
            push_slot = sel;
        end
        if (count_reg >= CNT_W'(MAX_TASKS))
        begin
            push_en = 1'b0;
        end
        push_sum = (IDX_W+1)'(head_reg) + (IDX_W+1)'(count_reg);
        if (push_sum >= (IDX_W+1)'(MAX_TASKS))
        begin
            push_sum = push_sum - (IDX_W+1)'(MAX_TASKS);
        end
        push_pos = push_sum[IDX_W-1:0];
    end

    // Status to controller
    always_comb
    begin
        status.in_load   = (in_command == CMD_LOAD);
        status.scan_last = scan_last;
        status.pop_need  = is_rr && !run_flag_reg;
        status.pop_end   = (count_reg == '0) || pop_found_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Slot tables and ring storage
    always_ff @(posedge clk)
    begin
        if (cmd.start && in_command == CMD_LOAD && load_ok)
        begin
            slot_arrival_reg[load_idx]   <= in_arrival;
            slot_burst_reg[load_idx]     <= in_burst;
            slot_remaining_reg[load_idx] <= in_burst;
            slot_priority_reg[load_idx]  <= in_priority;
            slot_done_reg[load_idx]      <= 1'b0;
        end
        if (cmd.exec && sel_valid)
        begin
            slot_remaining_reg[sel] <= rem_dec;
            if (finish)
            begin
                slot_done_reg[sel] <= 1'b1;
            end
        end
        if (push_en)
        begin
            ring_reg[push_pos] <= push_slot;
        end
    end

    // Queued flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_queued_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (push_en)
            begin
                slot_queued_reg[push_slot] <= 1'b1;
            end
            if (cmd.pop_step && count_reg != '0)
            begin
                slot_queued_reg[head_slot] <= 1'b0;
            end
        end
    end

    // Control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg     <= POL_FCFS;
            quantum_reg    <= QUANTUM_RESET;
            task_count_reg <= '0;
            clock_reg      <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            run_slot_reg   <= '0;
            run_flag_reg   <= 1'b0;
            slice_reg      <= '0;
            item_load_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            pop_found_reg  <= 1'b0;
            pop_slot_reg   <= '0;
            res_run_reg    <= 1'b0;
            res_slot_reg   <= '0;
            res_done_reg   <= 1'b0;
            res_turn_reg   <= '0;
            res_wait_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLICY:     policy_reg     <= cfg_wdata[1:0];
                    CFG_QUANTUM:    quantum_reg    <= cfg_wdata;
                    CFG_TASK_COUNT: task_count_reg <= cfg_wdata[TCOUNT_W-1:0];
                    default:        ;
                endcase
            end

            // new request
            if (cmd.start)
            begin
                item_load_reg  <= (in_command == CMD_LOAD);
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
                pop_found_reg  <= 1'b0;
                if (in_command == CMD_TICK && run_stale)
                begin
                    run_flag_reg <= 1'b0;
                end
            end

            // scan step
            if (cmd.scan_step)
            begin
                if (!scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (scan_take)
                begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= si;
                end
            end

            // ring count and head
            if (cmd.pop_step && count_reg != '0)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
                if (pop_hit)
                begin
                    pop_found_reg <= 1'b1;
                    pop_slot_reg  <= head_slot;
                end
            end
            else if (push_en)
            begin
                count_reg <= count_reg + 1'b1;
            end

            // execute one tick
            if (cmd.exec)
            begin
                if (clock_reg != TIME_MAX)
                begin
                    clock_reg <= clock_reg + 1'b1;
                end
                res_run_reg  <= sel_valid;
                res_slot_reg <= sel;
                res_done_reg <= sel_valid && finish;
                res_turn_reg <= turn;
                res_wait_reg <= wait_t;
                slice_reg    <= slice_base;
                if (sel_valid)
                begin
                    if (finish)
                    begin
                        run_flag_reg <= 1'b0;
                        slice_reg    <= '0;
                    end
                    else
                    begin
                        run_flag_reg <= !expire;
                        run_slot_reg <= sel;
                        if (is_rr)
                        begin
                            slice_reg <= expire ? '0 : slice_inc;
                        end
                    end
                end
            end

            // output handshake
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_time_reg <= clock_reg;
            out_all_reg  <= all_done;
            out_run_reg  <= !item_load_reg && res_run_reg;
            out_slot_reg <= item_load_reg || !res_run_reg ? '0 : SLOT_W'(res_slot_reg);
            out_done_reg <= !item_load_reg && res_done_reg;
            out_turn_reg <= (!item_load_reg && res_done_reg) ? res_turn_reg : '0;
            out_wait_reg <= (!item_load_reg && res_done_reg) ? res_wait_reg : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_time_now      = out_time_reg;
    assign out_running_valid = out_run_reg;
    assign out_running_slot  = out_slot_reg;
    assign out_done_valid    = out_done_reg;
    assign out_turnaround    = out_turn_reg;
    assign out_waiting       = out_wait_reg;
    assign out_all_done      = out_all_reg;

endmodule

FILE: hdl/cpu_task_scheduler.sv
// Sequence: a load request goes from acceptance straight to the emit state; a tick
// request steps through the one-slot-a-cycle scan, and under round robin with no
// task running it then pops ring entries (0 to MAX_TASKS) before it executes and
// emits; a stalled output holds the request in the emit state.
// Throughput: one request at a time; the next is accepted once the result
// of the previous one sits in the output register.
module cpu_task_scheduler import cts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    cts_in_if.sink                in_ch,
    cts_out_if.source             out_ch
);

    cts_cmd_t    cmd;
    cts_status_t status;
    logic        in_ready;

    assign in_ch.ready = in_ready;

    cts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_command        (in_ch.command),
        .in_slot_index     (in_ch.slot_index),
        .in_arrival        (in_ch.entry_arrival),
        .in_burst          (in_ch.entry_burst),
        .in_priority       (in_ch.entry_priority),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (out_ch.ready),
        .out_valid         (out_ch.valid),
        .out_time_now      (out_ch.time_now),
        .out_running_valid (out_ch.running_valid),
        .out_running_slot  (out_ch.running_slot),
        .out_done_valid    (out_ch.done_valid),
        .out_turnaround    (out_ch.turnaround),
        .out_waiting       (out_ch.waiting),
        .out_all_done      (out_ch.all_done)
    );

endmodule

FILE: bench/cts_sched_checker.sv
`timescale 1ns / 1ps

module cts_sched_checker import cts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    cts_in_if                     in_ch,
    cts_out_if                    out_ch,
    output int                    errors,
    output int                    pending
);

    localparam int NSLOT = MAX_TASKS_DEF;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic              running_valid;
        logic [SLOT_W-1:0] running_slot;
        logic              done_valid;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } sched_result_t;

    sched_result_t sched_q[$];

    // Shadow configuration
    logic [1:0]          pol_r;
    logic [QUANT_W-1:0]  quant_r;
    logic [TCOUNT_W-1:0] tcount_r;

    // Shadow scheduler state
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] arr   [NSLOT];
    logic [TIME_W-1:0] bur   [NSLOT];
    logic [TIME_W-1:0] rem   [NSLOT];
    logic [PRI_W-1:0]  pri   [NSLOT];
    logic              fin   [NSLOT];
    logic              queued[NSLOT];
    logic [SLOT_W-1:0] ring  [NSLOT];
    logic [SLOT_W-1:0] head;
    logic [3:0]        cnt;
    logic [SLOT_W-1:0] run_slot;
    logic              run_flag;
    logic [7:0]        slice;

    function automatic int in_use();
        return (tcount_r > NSLOT) ? NSLOT : int'(tcount_r);
    endfunction

    function automatic logic every_done();
        int n;
        n = in_use();
        for (int i = 0; i < n; i++)
            if (!fin[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void ring_push(int s);
        if (cnt >= NSLOT)
            return;
        ring[SLOT_W'(head + cnt)] = SLOT_W'(s);
        cnt = cnt + 1;
        queued[s] = 1'b1;
    endfunction

    function automatic int ring_pop(int n);
        int s;
        while (cnt > 0)
        begin
            s = ring[head];
            head = head + 1;
            cnt = cnt - 1;
            queued[s] = 1'b0;
            if (s < n && !fin[s])
                return s;
        end
        return -1;
    endfunction

    // Work out the result of one request and advance the shadow state
    function automatic sched_result_t schedule_step(logic cmd, logic [SLOT_W-1:0] sidx,
                                                    logic [TIME_W-1:0] a, logic [TIME_W-1:0] b,
                                                    logic [PRI_W-1:0] p);
        sched_result_t r;
        int n, t, pol, sel, best, s, q, done_at, turn, wt;
        r = '0;
        n = in_use();
        t = now_t;
        pol = (pol_r == POL_RESERVED) ? POL_FCFS : pol_r;
        sel = -1;
        best = -1;
        if (cmd == CMD_LOAD)
        begin
            arr[sidx] = a;
            bur[sidx] = b;
            rem[sidx] = b;
            pri[sidx] = p;
            fin[sidx] = 1'b0;
            r.time_now = now_t;
            r.all_done = every_done();
            return r;
        end
        if (run_flag && (run_slot >= n || fin[run_slot]))
            run_flag = 1'b0;
        if (pol == POL_RR)
        begin
            for (int i = 0; i < n; i++)
                if (!fin[i] && arr[i] <= t && !queued[i] && !(run_flag && i == run_slot))
                    ring_push(i);
            if (run_flag)
                sel = run_slot;
            else
            begin
                sel = ring_pop(n);
                slice = '0;
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (fin[i] || arr[i] > t)
                    continue;
                if (best < 0)
                    best = i;
                else if (pol == POL_PRIO && pri[i] < pri[best])
                    best = i;
                else if (pol == POL_FCFS && arr[i] < arr[best])
                    best = i;
            end
            if (run_flag)
            begin
                sel = run_slot;
                if (pol == POL_PRIO && best >= 0 && pri[best] < pri[run_slot])
                begin
                    sel = best;
                    slice = '0;
                end
            end
            else
            begin
                sel = best;
                slice = '0;
            end
        end
        if (sel >= 0)
        begin
            s = sel;
            r.running_valid = 1'b1;
            r.running_slot = SLOT_W'(s);
            if (rem[s] > 0)
                rem[s] = rem[s] - 1;
            if (rem[s] == 0)
            begin
                done_at = (t < TIME_MAX) ? t + 1 : TIME_MAX;
                turn = (done_at >= arr[s]) ? done_at - arr[s] : 0;
                wt = (turn >= bur[s]) ? turn - bur[s] : 0;
                fin[s] = 1'b1;
                run_flag = 1'b0;
                slice = '0;
                r.done_valid = 1'b1;
                r.turnaround = TIME_W'(turn);
                r.waiting = TIME_W'(wt);
            end
            else
            begin
                run_flag = 1'b1;
                run_slot = SLOT_W'(s);
                if (pol == POL_RR)
                begin
                    q = (quant_r == 0) ? 1 : quant_r;
                    slice = slice + 1;
                    if (slice >= q)
                    begin
                        ring_push(s);
                        run_flag = 1'b0;
                        slice = '0;
                    end
                end
            end
        end
        if (now_t < TIME_MAX)
            now_t = now_t + 1;
        r.time_now = now_t;
        r.all_done = every_done();
        return r;
    endfunction

    assign pending = sched_q.size();

    // Watch config, requests and results
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got, want;
        if (!rst_n)
        begin
            pol_r = POL_FCFS;
            quant_r = QUANTUM_RESET;
            tcount_r = '0;
            now_t = '0;
            head = '0;
            cnt = '0;
            run_slot = '0;
            run_flag = 1'b0;
            slice = '0;
            for (int i = 0; i < NSLOT; i++)
                queued[i] = 1'b0;
            sched_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_POLICY)
                    pol_r = cfg_wdata[1:0];
                else if (cfg_index == CFG_QUANTUM)
                    quant_r = cfg_wdata;
                else if (cfg_index == CFG_TASK_COUNT)
                    tcount_r = cfg_wdata[TCOUNT_W-1:0];
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.time_now, out_ch.running_valid, out_ch.running_slot,
                        out_ch.done_valid, out_ch.turnaround, out_ch.waiting,
                        out_ch.all_done};
                if (sched_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = sched_q.pop_front();
                    if (got.time_now !== want.time_now)
                    begin
                        $display("%0t: time_now exp %0d got %0d", $time,
                                 want.time_now, got.time_now);
                        errors++;
                    end
                    if (got.running_valid !== want.running_valid)
                    begin
                        $display("%0t: running_valid exp %0d got %0d", $time,
                                 want.running_valid, got.running_valid);
                        errors++;
                    end
                    if (got.running_slot !== want.running_slot)
                    begin
                        $display("%0t: running_slot exp %0d got %0d", $time,
                                 want.running_slot, got.running_slot);
                        errors++;
                    end
                    if (got.done_valid !== want.done_valid)
                    begin
                        $display("%0t: done_valid exp %0d got %0d", $time,
                                 want.done_valid, got.done_valid);
                        errors++;
                    end
                    if (got.turnaround !== want.turnaround)
                    begin
                        $display("%0t: turnaround exp %0d got %0d", $time,
                                 want.turnaround, got.turnaround);
                        errors++;
                    end
                    if (got.waiting !== want.waiting)
                    begin
                        $display("%0t: waiting exp %0d got %0d", $time,
                                 want.waiting, got.waiting);
                        errors++;
                    end
                    if (got.all_done !== want.all_done)
                    begin
                        $display("%0t: all_done exp %0d got %0d", $time,
                                 want.all_done, got.all_done);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                sched_q.push_back(schedule_step(in_ch.command, in_ch.slot_index,
                                                in_ch.entry_arrival, in_ch.entry_burst,
                                                in_ch.entry_priority));
        end
    end

endmodule

FILE: bench/cpu_task_scheduler_tb.sv
`timescale 1ns / 1ps

module cpu_task_scheduler_tb;
    import cts_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 2 * MAX_TASKS_DEF + 8;
    localparam int RANDOM_ITEMS = 800;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    errors;
    int                    pending;
    int                    cycles;
    int                    sent;
    int                    burst_left;
    int                    ticks_sent;
    int                    stall_mode;
    logic                  req_taken;

    cts_in_if  in_ch();
    cts_out_if out_ch();

    cpu_task_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    cts_sched_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (errors),
        .pending   (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    // Request handshake flag, read at the falling edge
    always @(posedge clk)
        req_taken <= in_ch.valid && in_ch.ready;

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("cpu_task_scheduler test failed");
            $finish;
        end
    end

    // Result side stalls, in one of four randomly chosen modes
    always @(negedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = ($urandom_range(0, 1) == 1);
            2: out_ch.ready = ((cycles % 8) < 2);
            default: out_ch.ready = ($urandom_range(0, 9) != 0);
        endcase
    end

    // One request; valid stays high across back-to-back requests
    task automatic send_req(logic cmd, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] a,
                            logic [TIME_W-1:0] b, logic [PRI_W-1:0] p);
        int gap;
        in_ch.valid = 1'b1;
        in_ch.command = cmd;
        in_ch.slot_index = s;
        in_ch.entry_arrival = a;
        in_ch.entry_burst = b;
        in_ch.entry_priority = p;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
        sent++;
        if (cmd == CMD_TICK && ticks_sent < 65535)
            ticks_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_tick();
        send_req(CMD_TICK, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                 PRI_W'($urandom));
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        int n, work, k;
        logic [TIME_W-1:0] a, b;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_POLICY;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_TICK;
        in_ch.slot_index = '0;
        in_ch.entry_arrival = '0;
        in_ch.entry_burst = '0;
        in_ch.entry_priority = '0;
        out_ch.ready = 1'b1;
        stall_mode = 0;
        cycles = 0;
        sent = 0;
        burst_left = 0;
        ticks_sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, zero burst, unused policy, zero quantum
        send_tick();
        send_req(CMD_LOAD, 3'd0, 16'd0, 16'd0, 8'd0);
        send_req(CMD_LOAD, 3'd1, 16'd0, 16'd3, 8'd255);
        send_req(CMD_LOAD, 3'd2, 16'd1, 16'd2, 8'd5);
        send_req(CMD_LOAD, 3'd3, 16'd1, 16'd2, 8'd5);
        send_req(CMD_LOAD, 3'd4, 16'd2, 16'd1, 8'd0);
        send_req(CMD_LOAD, 3'd5, 16'd0, 16'd2, 8'd128);
        send_req(CMD_LOAD, 3'd6, 16'hFFFF, 16'hFFFF, 8'd1);
        send_req(CMD_LOAD, 3'd7, 16'd3, 16'hFFFF, 8'd255);
        write_cfg(CFG_TASK_COUNT, 8'd8);
        write_cfg(CFG_POLICY, {6'b111111, POL_PRIO});
        repeat (5) send_tick();
        write_cfg(CFG_POLICY, {6'd0, POL_RR});
        write_cfg(CFG_QUANTUM, 8'd0);
        repeat (4) send_tick();
        write_cfg(CFG_POLICY, {6'd0, POL_RESERVED});
        repeat (3) send_tick();
        write_cfg(CFG_TASK_COUNT, 8'hFF);
        send_tick();

        // Random phases: load a task set, then tick it through
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_cfg(CFG_POLICY, CFG_DATA_W'($urandom));
            case ($urandom_range(0, 5))
                0: write_cfg(CFG_QUANTUM, 8'd0);
                1: write_cfg(CFG_QUANTUM, 8'd1);
                2: write_cfg(CFG_QUANTUM, 8'd255);
                3: write_cfg(CFG_QUANTUM, CFG_DATA_W'($urandom));
                default: write_cfg(CFG_QUANTUM, CFG_DATA_W'($urandom_range(2, 4)));
            endcase
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            write_cfg(CFG_TASK_COUNT, {CFG_DATA_W'($urandom)} & 8'hF0 | CFG_DATA_W'(k));
            n = (k > MAX_TASKS_DEF) ? MAX_TASKS_DEF : k;
            work = 0;
            for (int i = 0; i < n; i++)
            begin
                a = TIME_W'(ticks_sent + $urandom_range(0, 12));
                if ($urandom_range(0, 9) == 0)
                    a = TIME_W'($urandom);
                b = TIME_W'($urandom_range(1, 6));
                if ($urandom_range(0, 19) == 0)
                    b = '0;
                else if ($urandom_range(0, 29) == 0)
                    b = TIME_W'($urandom);
                work += (b > 20) ? 20 : b;
                send_req(CMD_LOAD, SLOT_W'(i), a, b, PRI_W'($urandom));
                if ($urandom_range(0, 9) == 0)
                    send_tick();
            end
            if ($urandom_range(0, 3) == 0)
                wait_idle();
            work = work + 15;
            for (int i = 0; i < work; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    send_req(CMD_LOAD, SLOT_W'($urandom), TIME_W'(ticks_sent +
                             $urandom_range(0, 5)), TIME_W'($urandom_range(0, 4)),
                             PRI_W'($urandom));
                else
                    send_tick();
            end
        end

        // Drain
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("cpu_task_scheduler test passed");
        else
            $display("cpu_task_scheduler test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/cts_pkg.sv
hdl/cts_in_if.sv
hdl/cts_out_if.sv
hdl/cts_ctrl.sv
hdl/cts_datapath.sv
hdl/cpu_task_scheduler.sv
bench/cts_sched_checker.sv
bench/cpu_task_scheduler_tb.sv
